[rtl/calendar_date_offset_and_difference_defines.svh]
// assertion macros for the calendar date offset and difference block
// expects signals named clk and rst in the scope where a macro is used
`ifndef CALENDAR_DATE_OFFSET_AND_DIFFERENCE_DEFINES_SVH
`define CALENDAR_DATE_OFFSET_AND_DIFFERENCE_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define CDOD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define CDOD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cdod_pkg.sv]
// shared constants, codes, month table and controller/datapath interface structs
// for the calendar date offset and difference block; no dependencies
package cdod_pkg;

  // default upper year limit
  localparam int unsigned MAX_YEAR_DEF = 9999;

  // field widths
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int OFF_W   = 23;
  localparam int STAT_W  = 2;

  // gregorian cycle lengths
  localparam int CYCLE_YEARS   = 400;
  localparam int CENTURY_YEARS = 100;
  localparam int LEAP_YEARS    = 4;
  localparam int MONTHS        = 12;
  localparam int DAYS_400      = 146097;
  localparam int DAYS_100      = 36524;
  localparam int DAYS_4        = 1461;
  localparam int DAYS_1        = 365;

  // year position inside the 400 year cycle, and day chunk widths
  localparam int CYC_W = 9;
  localparam int DL_W  = 18;

  // signed difference limits
  localparam int DIFF_MAX = (2 ** (OFF_W - 1)) - 1;
  localparam int DIFF_MIN = -(2 ** (OFF_W - 1));

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DATE = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_DATE,
    RES_DIFF
  } res_kind_t;

  // commands from controller to datapath
  typedef struct packed {
    logic      load;
    logic      walk_init;
    logic      sel2;
    logic      consume;
    logic      yr_step;
    logic      mo_step;
    logic      add_day;
    logic      add_off;
    logic      save_n1;
    logic      out_load;
    res_kind_t kind;
    status_t   status;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic op;
    logic bad_a;
    logic bad_b;
    logic year_done;
    logic month_done;
    logic day_bad;
    logic range_bad;
  } dp_stat_t;

  // month length table
  function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                 input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

[rtl/calendar_date_offset_and_difference.sv]
// Gregorian date add-days and day-difference unit, one transaction at a time. A request is
// taken only while the block is idle; it turns each date into a day number counted from
// 0000-01-01 by walking years in aligned chunks of 400, 100, 4 or 1 years and then whole
// months, one step per cycle in the shared year/month step unit, and for an add it walks
// back down from the summed day number the same way. A bad month, a day of 0 or a year
// above MAX_YEAR finishes straight from the check state; a day past the end of its month
// is caught after the year walk of that date. The finished result sits in an output
// register, so the next request is taken while it waits; a result still waiting holds the
// next one at its end. Status 1 flags an invalid input date, status 2 an add whose result
// falls outside year 0 to MAX_YEAR; other fields are 0.
// depends on cdod_pkg, cdod_ctrl, cdod_dp and the assertion macro header
`include "calendar_date_offset_and_difference_defines.svh"

module calendar_date_offset_and_difference
  import cdod_pkg::*;
#(
  parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  logic                     op,
  input  logic [YEAR_W-1:0]        year,
  input  logic [MONTH_W-1:0]       month,
  input  logic [DAY_W-1:0]         day_of_month,
  input  logic signed [OFF_W-1:0]  offset,
  input  logic [YEAR_W-1:0]        other_year,
  input  logic [MONTH_W-1:0]       other_month,
  input  logic [DAY_W-1:0]         other_day,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output logic [YEAR_W-1:0]        result_year,
  output logic [MONTH_W-1:0]       result_month,
  output logic [DAY_W-1:0]         result_day,
  output logic signed [OFF_W-1:0]  difference,
  output logic [STAT_W-1:0]        status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  cdod_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // date arithmetic
  cdod_dp #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .stat         (stat),
    .op           (op),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .offset       (offset),
    .other_year   (other_year),
    .other_month  (other_month),
    .other_day    (other_day),
    .result_year  (result_year),
    .result_month (result_month),
    .result_day   (result_day),
    .difference   (difference),
    .status       (status)
  );

  // checks
  `CDOD_ASSERT_NEXT(a_single_in_flight, req_valid && req_ready, !req_ready, "request taken while busy")
  `CDOD_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !rsp_valid || rsp_ready, "pending result overwritten")
  `CDOD_ASSERT_IMPL(a_error_zero, rsp_valid && (status != ST_OK), (result_year == '0) && (result_month == '0) && (result_day == '0) && (difference == '0), "error result not cleared")
  `CDOD_ASSERT_IMPL(a_date_shape, rsp_valid && (result_month != '0), (result_month <= 4'd12) && (result_day != '0) && (difference == '0), "malformed result date")

endmodule

[rtl/cdod_dp.sv]
// datapath: input capture, year/month walk unit, day number accumulator and result registers
// depends on cdod_pkg
module cdod_dp
  import cdod_pkg::*;
#(
  parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
  input  logic                     clk,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 stat,
  input  logic                     op,
  input  logic [YEAR_W-1:0]        year,
  input  logic [MONTH_W-1:0]       month,
  input  logic [DAY_W-1:0]         day_of_month,
  input  logic signed [OFF_W-1:0]  offset,
  input  logic [YEAR_W-1:0]        other_year,
  input  logic [MONTH_W-1:0]       other_month,
  input  logic [DAY_W-1:0]         other_day,
  output logic [YEAR_W-1:0]        result_year,
  output logic [MONTH_W-1:0]       result_month,
  output logic [DAY_W-1:0]         result_day,
  output logic signed [OFF_W-1:0]  difference,
  output logic [STAT_W-1:0]        status
);

  localparam int YW     = $clog2(MAX_YEAR + 1);
  localparam int CW     = ((YW > YEAR_W) ? YW : YEAR_W) + 1;
  localparam int LAST   = (MAX_YEAR + 1) * 365 + MAX_YEAR / 4 - MAX_YEAR / 100
                          + MAX_YEAR / 400;
  localparam int LAST_W = $clog2(LAST + 1);
  localparam int DN_W   = ((LAST_W > OFF_W) ? LAST_W : OFF_W) + 2;

  localparam logic signed [DN_W-1:0] LAST_S = DN_W'(LAST);
  localparam logic signed [DN_W-1:0] DMAX_S = DN_W'(DIFF_MAX);
  localparam logic signed [DN_W-1:0] DMIN_S = DN_W'(DIFF_MIN);
  localparam logic [CW-1:0]          MAXY_X = CW'(MAX_YEAR);

  typedef enum logic [2:0] {
    CH_NONE,
    CH_1,
    CH_4,
    CH_100,
    CH_400
  } chunk_t;

  // captured transaction
  logic                    sel_op;
  logic [YEAR_W-1:0]       yr_a, yr_b;
  logic [MONTH_W-1:0]      mo_a, mo_b;
  logic [DAY_W-1:0]        dy_a, dy_b;
  logic signed [OFF_W-1:0] ofs;

  // walk state
  logic [YW-1:0]           yy;
  logic [CYC_W-1:0]        cyc;
  logic [MONTH_W-1:0]      mm;
  logic signed [DN_W-1:0]  acc;
  logic signed [DN_W-1:0]  n_first;

  logic [YEAR_W-1:0]       ty;
  logic [MONTH_W-1:0]      tm;
  logic [DAY_W-1:0]        td;
  logic [CW-1:0]           yy_x, ty_x;
  logic                    lp400, cent, quad, leap;
  logic [DL_W-1:0]         len100, len4, len1, dlen;
  logic signed [DN_W-1:0]  d400_s, d100_s, d4_s, d1_s, dlen_s, mdays_s, td_s, ofs_s;
  logic                    f400, f100, f4, f1;
  chunk_t                  chunk;
  logic [CYC_W-1:0]        ystep, cyc_next;
  logic [CYC_W:0]          cyc_sum;
  logic [DAY_W-1:0]        mdays, mdays_t;
  logic signed [DN_W-1:0]  dval;
  logic [CW-1:0]           yy_res;

  // walk target selects the first or second date
  assign ty = cmd.sel2 ? yr_b : yr_a;
  assign tm = cmd.sel2 ? mo_b : mo_a;
  assign td = cmd.sel2 ? dy_b : dy_a;

  assign yy_x = CW'(yy);
  assign ty_x = CW'(ty);

  // leap structure of the current year from its place in the 400 year cycle
  assign lp400 = (cyc == '0);
  assign cent  = (cyc == '0) || (cyc == CYC_W'(CENTURY_YEARS))
              || (cyc == CYC_W'(2 * CENTURY_YEARS)) || (cyc == CYC_W'(3 * CENTURY_YEARS));
  assign quad  = (cyc[1:0] == 2'b00);
  assign leap  = lp400 || (quad && !cent);

  assign len100 = lp400 ? DL_W'(DAYS_100 + 1) : DL_W'(DAYS_100);
  assign len4   = (cent && !lp400) ? DL_W'(DAYS_4 - 1) : DL_W'(DAYS_4);
  assign len1   = leap ? DL_W'(DAYS_1 + 1) : DL_W'(DAYS_1);

  assign d400_s = DN_W'(DAYS_400);
  assign d100_s = $signed({{(DN_W-DL_W){1'b0}}, len100});
  assign d4_s   = $signed({{(DN_W-DL_W){1'b0}}, len4});
  assign d1_s   = $signed({{(DN_W-DL_W){1'b0}}, len1});

  // largest aligned chunk of years that still fits
  always_comb begin
    if (cmd.consume) begin
      f400 = lp400 && (acc >= d400_s);
      f100 = cent && (acc >= d100_s);
      f4   = quad && (acc >= d4_s);
      f1   = (acc >= d1_s);
    end else begin
      f400 = lp400 && (yy_x + CW'(CYCLE_YEARS) <= ty_x);
      f100 = cent && (yy_x + CW'(CENTURY_YEARS) <= ty_x);
      f4   = quad && (yy_x + CW'(LEAP_YEARS) <= ty_x);
      f1   = (yy_x < ty_x);
    end
    if (f400)      chunk = CH_400;
    else if (f100) chunk = CH_100;
    else if (f4)   chunk = CH_4;
    else if (f1)   chunk = CH_1;
    else           chunk = CH_NONE;
  end

  always_comb begin
    case (chunk)
      CH_400:  begin ystep = CYC_W'(CYCLE_YEARS);   dlen = DL_W'(DAYS_400); end
      CH_100:  begin ystep = CYC_W'(CENTURY_YEARS); dlen = len100;          end
      CH_4:    begin ystep = CYC_W'(LEAP_YEARS);    dlen = len4;            end
      CH_1:    begin ystep = CYC_W'(1);             dlen = len1;            end
      default: begin ystep = '0;                    dlen = '0;              end
    endcase
  end

  assign dlen_s   = $signed({{(DN_W-DL_W){1'b0}}, dlen});
  assign cyc_sum  = {1'b0, cyc} + {1'b0, ystep};
  assign cyc_next = (cyc_sum >= (CYC_W+1)'(CYCLE_YEARS))
                  ? CYC_W'(cyc_sum - (CYC_W+1)'(CYCLE_YEARS)) : CYC_W'(cyc_sum);

  // month lengths for the walk and for the day check
  assign mdays   = month_days(leap, mm);
  assign mdays_t = month_days(leap, tm);
  assign mdays_s = $signed({{(DN_W-DAY_W){1'b0}}, mdays});
  assign td_s    = $signed({{(DN_W-DAY_W){1'b0}}, td});
  assign ofs_s   = {{(DN_W-OFF_W){ofs[OFF_W-1]}}, ofs};

  // status to the controller
  assign stat.op         = sel_op;
  assign stat.bad_a      = (CW'(yr_a) > MAXY_X) || (mo_a == '0)
                        || (mo_a > MONTH_W'(MONTHS)) || (dy_a == '0);
  assign stat.bad_b      = (CW'(yr_b) > MAXY_X) || (mo_b == '0)
                        || (mo_b > MONTH_W'(MONTHS)) || (dy_b == '0);
  assign stat.year_done  = (chunk == CH_NONE);
  assign stat.month_done = cmd.consume ? ((mm == MONTH_W'(MONTHS)) || (acc < mdays_s))
                                       : (mm == tm);
  assign stat.day_bad    = (td > mdays_t);
  assign stat.range_bad  = (acc < 0) || (acc > LAST_S);

  assign dval   = n_first - acc;
  assign yy_res = CW'(yy);

  // capture transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sel_op <= op;
      yr_a   <= year;
      mo_a   <= month;
      dy_a   <= day_of_month;
      ofs    <= offset;
      yr_b   <= other_year;
      mo_b   <= other_month;
      dy_b   <= other_day;
    end
  end

  // walk registers and day number accumulator
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      yy  <= '0;
      cyc <= '0;
      mm  <= MONTH_W'(1);
      if (!cmd.consume) begin
        acc <= '0;
      end
    end else if (cmd.yr_step) begin
      yy  <= YW'(yy_x + CW'(ystep));
      cyc <= cyc_next;
      acc <= cmd.consume ? (acc - dlen_s) : (acc + dlen_s);
    end else if (cmd.mo_step) begin
      mm  <= mm + MONTH_W'(1);
      acc <= cmd.consume ? (acc - mdays_s) : (acc + mdays_s);
    end else if (cmd.add_day) begin
      acc <= acc + td_s - DN_W'(1);
    end else if (cmd.add_off) begin
      acc <= acc + ofs_s;
    end
    if (cmd.save_n1) begin
      n_first <= acc;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status       <= cmd.status;
      result_year  <= '0;
      result_month <= '0;
      result_day   <= '0;
      difference   <= '0;
      case (cmd.kind)
        RES_DATE: begin
          result_year  <= yy_res[YEAR_W-1:0];
          result_month <= mm;
          result_day   <= acc[DAY_W-1:0] + DAY_W'(1);
        end
        RES_DIFF: begin
          if (dval > DMAX_S) begin
            difference <= DMAX_S[OFF_W-1:0];
          end else if (dval < DMIN_S) begin
            difference <= DMIN_S[OFF_W-1:0];
          end else begin
            difference <= dval[OFF_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/cdod_ctrl.sv]
// controller: sequences check, year walk, month walk and result hand-off
// depends on cdod_pkg; drives the datapath through dp_cmd_t
module cdod_ctrl
  import cdod_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_YEARS,
    S_MONTHS,
    S_DAY,
    S_NEXT,
    S_RANGE,
    S_DONE
  } state_t;

  state_t    state;
  logic      sel2;
  logic      consume;
  res_kind_t kind;
  status_t   code;

  assign req_ready = (state == S_IDLE);

  // commands decoded from state and datapath status
  always_comb begin
    cmd          = '0;
    cmd.sel2     = sel2;
    cmd.consume  = consume;
    cmd.kind     = kind;
    cmd.status   = code;
    unique case (state)
      S_IDLE:   cmd.load = req_valid;
      S_CHECK:  cmd.walk_init = !(stat.bad_a || (stat.op && stat.bad_b));
      S_YEARS:  cmd.yr_step = !stat.year_done;
      S_MONTHS: cmd.mo_step = !stat.month_done;
      S_DAY:    cmd.add_day = 1'b1;
      S_NEXT: begin
        if (!stat.op) begin
          cmd.add_off = 1'b1;
        end else if (!sel2) begin
          cmd.save_n1   = 1'b1;
          cmd.walk_init = 1'b1;
        end
      end
      S_RANGE:  cmd.walk_init = !stat.range_bad;
      S_DONE:   cmd.out_load = !rsp_valid || rsp_ready;
      default: begin
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      sel2      <= 1'b0;
      consume   <= 1'b0;
      kind      <= RES_NONE;
      code      <= ST_OK;
    end else begin
      // in S_DONE the result hand-off below sets valid again
      if (rsp_valid && rsp_ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            sel2    <= 1'b0;
            consume <= 1'b0;
            state   <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (stat.bad_a || (stat.op && stat.bad_b)) begin
            kind  <= RES_NONE;
            code  <= ST_BAD_DATE;
            state <= S_DONE;
          end else begin
            state <= S_YEARS;
          end
        end
        S_YEARS: begin
          if (stat.year_done) begin
            if (!consume && stat.day_bad) begin
              kind  <= RES_NONE;
              code  <= ST_BAD_DATE;
              state <= S_DONE;
            end else begin
              state <= S_MONTHS;
            end
          end
        end
        S_MONTHS: begin
          if (stat.month_done) begin
            if (consume) begin
              kind  <= RES_DATE;
              code  <= ST_OK;
              state <= S_DONE;
            end else begin
              state <= S_DAY;
            end
          end
        end
        S_DAY: state <= S_NEXT;
        S_NEXT: begin
          if (!stat.op) begin
            consume <= 1'b1;
            state   <= S_RANGE;
          end else if (!sel2) begin
            sel2  <= 1'b1;
            state <= S_YEARS;
          end else begin
            kind  <= RES_DIFF;
            code  <= ST_OK;
            state <= S_DONE;
          end
        end
        S_RANGE: begin
          if (stat.range_bad) begin
            kind  <= RES_NONE;
            code  <= ST_RANGE;
            state <= S_DONE;
          end else begin
            state <= S_YEARS;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
